[sv/assert_macros.svh]
// Assertion helpers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed: %m");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: %m");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif

`endif

[sv/tccc_pkg.sv]
package tccc_pkg;

  // Field widths
  localparam int COL_W  = 9;
  localparam int ROW_W  = 10;
  localparam int CHAR_W = 8;
  localparam int STEP_W = 4;

  // Console geometry
  localparam int GLYPH_WIDTH  = 8;
  localparam int SCREEN_WIDTH = 320;
  localparam int LINE_HEIGHT  = 10;
  localparam int ROW_LIMIT    = 1023;
  localparam int CELL_STEP    = GLYPH_WIDTH + 1;

  localparam logic [COL_W-1:0] CELL_C      = COL_W'(CELL_STEP);
  localparam logic [COL_W-1:0] SCREEN_W_C  = COL_W'(SCREEN_WIDTH);
  localparam logic [COL_W-1:0] EDGE_COL_C  = COL_W'(SCREEN_WIDTH - 2);
  localparam logic [COL_W-1:0] BS_COL_C    = COL_W'(SCREEN_WIDTH - GLYPH_WIDTH + 1);
  localparam logic [ROW_W-1:0] LINE_H_C    = ROW_W'(LINE_HEIGHT);
  localparam logic [ROW_W-1:0] ROW_LIMIT_C = ROW_W'(ROW_LIMIT);

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

  // Result kinds
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_CURSOR = 1'b1;

  // Index of the final result per transaction type
  localparam logic [STEP_W-1:0] STEP_FIRST    = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_GLYPH_LAST = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_TAB_LAST = STEP_W'(8);

  typedef struct packed {
    logic              kind;
    logic [COL_W-1:0]  pos_x;
    logic [ROW_W-1:0]  pos_y;
    logic [CHAR_W-1:0] glyph_color;
    logic [CHAR_W-1:0] glyph_code;
    logic              last;
  } result_t;

endpackage

[sv/text_console_cursor_control_top.sv]
// Cursor tracking for a pixel-addressed text console. Each input transaction is
// one character byte; the block answers with glyph draw commands and cursor
// updates, one result per cycle from its single output register unless out_stall
// holds it, the final one flagged by out_last. Newline, carriage return and
// backspace at column zero give one result, a printable glyph or any other
// backspace three, a tab nine. The next character is taken in the cycle the
// previous character's last result is loaded, so one-result characters stream
// at one per clock while out_stall is low. text_color may be written only while
// the block is idle.
`include "assert_macros.svh"

module text_console_cursor_control_top
  import tccc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [COL_W-1:0]  out_pos_x,
  output logic [ROW_W-1:0]  out_pos_y,
  output logic [CHAR_W-1:0] out_glyph_color,
  output logic [CHAR_W-1:0] out_glyph_code,
  output logic              out_last
);

  logic [CHAR_W-1:0] color_r;
  logic              busy_r;
  logic [CHAR_W-1:0] code_r;
  logic [STEP_W-1:0] step_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              out_valid_r;
  result_t           res_r, res_nxt;

  logic              advance;
  logic              in_accept;
  logic              is_last;
  logic              is_draw;
  logic [STEP_W-1:0] last_step;
  logic [COL_W-1:0]  back_col, pre_col, draw_col;
  logic [ROW_W-1:0]  row_dn, row_up, draw_row;
  logic [ROW_W:0]    row_sum;
  logic [COL_W:0]    col_sum;
  logic              wrap;
  logic              col_zero;
  logic              glyph_op;
  logic [CHAR_W-1:0] draw_code;

  // While busy, emit a result whenever the output register is free or drains
  assign advance   = busy_r && (!out_valid_r || !out_stall);
  assign in_stall  = busy_r && !(advance && is_last);
  assign in_accept = in_valid && !in_stall;

  // Cursor arithmetic
  assign col_zero = (col_r == '0);
  assign back_col = (col_r < CELL_C) ? '0 : col_r - CELL_C;
  assign row_sum  = {1'b0, row_r} + {1'b0, LINE_H_C};
  assign row_dn   = (row_sum > {1'b0, ROW_LIMIT_C}) ? ROW_LIMIT_C : row_sum[ROW_W-1:0];
  assign row_up   = (row_r < LINE_H_C) ? '0 : row_r - LINE_H_C;

  // Backspace steps back one cell before printing its space
  assign pre_col  = (code_r == CHAR_BS) ? back_col : col_r;
  assign col_sum  = {1'b0, pre_col} + {1'b0, CELL_C};
  assign wrap     = (pre_col >= EDGE_COL_C) || (col_sum >= {1'b0, SCREEN_W_C});
  assign draw_col = wrap ? '0 : pre_col;
  assign draw_row = wrap ? row_dn : row_r;

  // Decode the transaction type
  always_comb begin
    glyph_op  = 1'b1;
    last_step = STEP_GLYPH_LAST;
    draw_code = code_r;
    unique case (code_r)
      CHAR_NL, CHAR_CR: begin
        glyph_op  = 1'b0;
        last_step = STEP_FIRST;
      end
      CHAR_TAB: begin
        last_step = STEP_TAB_LAST;
        draw_code = CHAR_SPACE;
      end
      CHAR_BS: begin
        draw_code = CHAR_SPACE;
        if (step_r == STEP_FIRST && col_zero) begin
          glyph_op  = 1'b0;
          last_step = STEP_FIRST;
        end
      end
      default: begin
        glyph_op  = 1'b1;
      end
    endcase
  end

  assign is_last = (step_r == last_step);
  assign is_draw = glyph_op && !step_r[0] && !is_last;

  // Build the next result and the cursor it leaves behind
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    res_nxt = '{kind: KIND_CURSOR, pos_x: col_r, pos_y: row_r,
                glyph_color: '0, glyph_code: '0, last: is_last};
    if (is_last) begin
      case (code_r)
        CHAR_NL: begin
          row_nxt = row_dn;
          col_nxt = '0;
        end
        CHAR_CR: begin
          col_nxt = '0;
        end
        CHAR_BS: begin
          if (step_r != STEP_FIRST) begin
            col_nxt = back_col;
          end else if (row_r != '0) begin
            row_nxt = row_up;
            col_nxt = BS_COL_C;
          end
        end
        default: begin
          col_nxt = col_r;
        end
      endcase
      res_nxt.pos_x = col_nxt;
      res_nxt.pos_y = row_nxt;
    end else if (is_draw) begin
      col_nxt             = draw_col + CELL_C;
      row_nxt             = draw_row;
      res_nxt.kind        = KIND_DRAW;
      res_nxt.pos_x       = draw_col;
      res_nxt.pos_y       = draw_row;
      res_nxt.glyph_color = color_r;
      res_nxt.glyph_code  = draw_code;
    end
  end

  // Control state: color, item sequencer, cursor, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r     <= 8'd2;
      busy_r      <= 1'b0;
      step_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
      if (in_accept) begin
        busy_r <= 1'b1;
        step_r <= STEP_FIRST;
      end else if (advance) begin
        if (is_last) begin
          busy_r <= 1'b0;
        end
        step_r <= step_r + STEP_W'(1);
      end
      if (advance) begin
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      code_r <= in_char_code;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = res_r.kind;
  assign out_pos_x       = res_r.pos_x;
  assign out_pos_y       = res_r.pos_y;
  assign out_glyph_color = res_r.glyph_color;
  assign out_glyph_code  = res_r.glyph_code;
  assign out_last        = res_r.last;

  // Checks
  `ASSERT_IMPLY(a_step_range, clk, rst_n, busy_r, step_r <= STEP_TAB_LAST)
  `ASSERT_IMPLY(a_accept_on_last, clk, rst_n, in_accept && busy_r, advance && is_last)
  `ASSERT_ALWAYS(a_col_on_screen, clk, rst_n, col_r < SCREEN_W_C)
  `ASSERT_ALWAYS(a_row_limit, clk, rst_n, row_r <= ROW_LIMIT_C)
  `ASSERT_IMPLY(a_draw_not_last, clk, rst_n, advance && is_draw, !is_last && glyph_op)

endmodule

[dv/testbench.sv]
module testbench;
  import tccc_pkg::*;

  localparam int TAB_CELLS   = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 12;

  // Scoreboard: tracks the console cursor and queues the draws and updates it predicts
  class console_scoreboard;
    int unsigned       column;
    int unsigned       row;
    logic [CHAR_W-1:0] text_color;
    result_t           console_results[$];
    int                errors;
    int                results_seen;
    int                wraps;
    int                row_clips;
    int                row_floors;
    int                column_floors;

    function new();
      column        = 0;
      row           = 0;
      text_color    = 8'd2;
      errors        = 0;
      results_seen  = 0;
      wraps         = 0;
      row_clips     = 0;
      row_floors    = 0;
      column_floors = 0;
    endfunction

    function int pending();
      return console_results.size();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 40)
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Queue one result at the current cursor position
    function void post(input logic kind, input logic [CHAR_W-1:0] code);
      result_t r;
      r.kind        = kind;
      r.pos_x       = COL_W'(column);
      r.pos_y       = ROW_W'(row);
      r.glyph_color = (kind == KIND_DRAW) ? text_color : '0;
      r.glyph_code  = (kind == KIND_DRAW) ? code : '0;
      r.last        = 1'b0;
      console_results.push_back(r);
    endfunction

    // Move down one line, clamped at the row limit
    function void line_down();
      if (row + LINE_HEIGHT > ROW_LIMIT) begin
        row = ROW_LIMIT;
        row_clips++;
      end else begin
        row += LINE_HEIGHT;
      end
    endfunction

    // Step back one cell, clamped at column zero
    function void cell_back();
      if (column < CELL_STEP) begin
        column = 0;
        column_floors++;
      end else begin
        column -= CELL_STEP;
      end
    endfunction

    // Wrap if the cell would reach the edge, draw, advance, update
    function void draw_cell(input logic [CHAR_W-1:0] code);
      if (column >= SCREEN_WIDTH - 2 || column + CELL_STEP >= SCREEN_WIDTH) begin
        line_down();
        column = 0;
        wraps++;
      end
      post(KIND_DRAW, code);
      column += CELL_STEP;
      post(KIND_CURSOR, '0);
    endfunction

    // Predict every result one character causes
    function void advance_cursor(input logic [CHAR_W-1:0] c);
      result_t tail;
      case (c)
        CHAR_NL: begin
          line_down();
          column = 0;
        end
        CHAR_BS: begin
          // stay put at the origin
          if (column != 0 || row != 0) begin
            if (column == 0) begin
              if (row < LINE_HEIGHT) begin
                row = 0;
                row_floors++;
              end else begin
                row -= LINE_HEIGHT;
              end
              column = SCREEN_WIDTH - GLYPH_WIDTH + 1;
            end else begin
              cell_back();
              draw_cell(CHAR_SPACE);
              cell_back();
            end
          end
        end
        CHAR_TAB: repeat (TAB_CELLS) draw_cell(CHAR_SPACE);
        CHAR_CR:  column = 0;
        default:  draw_cell(c);
      endcase
      post(KIND_CURSOR, '0);
      tail = console_results.pop_back();
      tail.last = 1'b1;
      console_results.push_back(tail);
    endfunction

    // Compare one accepted result with the oldest prediction
    task check_result(input result_t got);
      result_t want;
      if (console_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d at (%0d,%0d)",
                         got.kind, got.pos_x, got.pos_y));
        return;
      end
      want = console_results.pop_front();
      results_seen++;
      if (got.kind !== want.kind)
        report($sformatf("result %0d kind %0d, want %0d", results_seen, got.kind, want.kind));
      if (got.pos_x !== want.pos_x)
        report($sformatf("result %0d pos_x %0d, want %0d",
                         results_seen, got.pos_x, want.pos_x));
      if (got.pos_y !== want.pos_y)
        report($sformatf("result %0d pos_y %0d, want %0d",
                         results_seen, got.pos_y, want.pos_y));
      if (got.glyph_color !== want.glyph_color)
        report($sformatf("result %0d glyph_color %0h, want %0h",
                         results_seen, got.glyph_color, want.glyph_color));
      if (got.glyph_code !== want.glyph_code)
        report($sformatf("result %0d glyph_code %0h, want %0h",
                         results_seen, got.glyph_code, want.glyph_code));
      if (got.last !== want.last)
        report($sformatf("result %0d last %0d, want %0d", results_seen, got.last, want.last));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CHAR_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [CHAR_W-1:0] in_char_code;
  logic              out_valid;
  logic              out_stall;
  logic              out_kind;
  logic [COL_W-1:0]  out_pos_x;
  logic [ROW_W-1:0]  out_pos_y;
  logic [CHAR_W-1:0] out_glyph_color;
  logic [CHAR_W-1:0] out_glyph_code;
  logic              out_last;

  console_scoreboard sb;
  int  chars_sent   = 0;
  int  tx_pct       = 0;
  int  rx_pct       = 0;
  bit  calm         = 1'b0;
  int  holds_asked  = 0;
  int  holds_served = 0;

  text_console_cursor_control_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_glyph_color (out_glyph_color),
    .out_glyph_code  (out_glyph_code),
    .out_last        (out_last)
  );

  always #1 clk = ~clk;

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(result_t'{kind: out_kind, pos_x: out_pos_x, pos_y: out_pos_y,
                                glyph_color: out_glyph_color, glyph_code: out_glyph_code,
                                last: out_last});
  end

  // Drive result-side stall: long hold-offs on request, short random bursts otherwise
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && rx_pct > 0 && $urandom_range(0, 99) < rx_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one character, hold it until accepted, then maybe idle
  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < tx_pct) ? $urandom_range(1, 9) : 0;
    in_valid     <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (in_stall);
    sb.advance_cursor(c);
    chars_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_color(input logic [CHAR_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.text_color = v;
  endtask

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [CHAR_W-1:0] opening[];
    logic [CHAR_W-1:0] c;
    int                stop;
    int                n;
    int                newlines;
    int                i;

    sb           = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_char_code = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: backspace at origin, byte extremes, return, nine tabs to force a wrap,
    // backspace mid-line and at column zero, glyph wrap from the backspace column
    opening = '{CHAR_BS, 8'h41, 8'h00, 8'hFF, CHAR_CR,
                CHAR_TAB, CHAR_TAB, CHAR_TAB, CHAR_TAB, CHAR_TAB,
                CHAR_TAB, CHAR_TAB, CHAR_TAB, CHAR_TAB,
                CHAR_BS, CHAR_BS, 8'h5A, CHAR_NL, CHAR_CR, CHAR_BS,
                CHAR_SPACE, 8'h7F, CHAR_TAB};
    foreach (opening[k]) send_char(opening[k]);
    wait_idle();
    set_color(8'hFF);

    // Fill the block while the receiver holds off
    tx_pct = 20;
    rx_pct = 20;
    holds_asked <= holds_asked + 1;
    for (i = 0; i < 12; i++)
      send_char((i % 3 == 0) ? 8'($urandom_range(0, 255)) : CHAR_TAB);

    // Mixed bursts of text, rub-outs, tabs and line control
    stop = chars_sent + 70;
    while (chars_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 40)) send_char(8'($urandom_range(0, 255)));
        4, 5:       repeat ($urandom_range(1, 45)) send_char(CHAR_BS);
        6:          repeat ($urandom_range(1, 10)) send_char(CHAR_TAB);
        7: begin
          repeat ($urandom_range(1, 4)) send_char(CHAR_NL);
          send_char(CHAR_CR);
        end
        8: repeat ($urandom_range(1, 3)) begin
          send_char(CHAR_CR);
          send_char(CHAR_BS);
        end
        default: repeat ($urandom_range(1, 5)) send_char(8'($urandom_range(0, 255)));
      endcase
    end
    wait_idle();
    set_color(8'h00);

    // Scroll down past the row limit, with stray glyphs between newlines
    tx_pct   = 30;
    rx_pct   = 10;
    newlines = 0;
    while (newlines < 105) begin
      if ($urandom_range(0, 99) < 85) begin
        send_char(CHAR_NL);
        newlines++;
      end else begin
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_BS || c == CHAR_NL) c = 8'h2A;
        send_char(c);
      end
    end
    wait_idle();
    set_color(8'($urandom_range(1, 254)));

    // Climb back to the top with return plus backspace pairs; quiet in the last stretch
    tx_pct = 15;
    rx_pct = 25;
    for (i = 0; i < 106; i++) begin
      if (i == 60) calm = 1'b1;
      if ($urandom_range(0, 99) < 10) begin
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_BS || c == CHAR_NL || c == CHAR_CR) c = 8'h41;
        send_char(c);
      end
      send_char(CHAR_CR);
      send_char(CHAR_BS);
    end

    // Drain, bounded, then let any stray results show up
    in_valid <= 1'b0;
    for (n = 0; n < 20000 && sb.pending() > 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() > 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending()));

    $display("Ran %0d characters, %0d results checked, under four text colors.",
             chars_sent, sb.results_seen);
    $display("Line wraps %0d, clamps at row limit %0d, at top row %0d, at column zero %0d.",
             sb.wraps, sb.row_clips, sb.row_floors, sb.column_floors);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
